// ===== src/esu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package esu_pkg;

  // Most bytes that one input byte can release: three UTF-8 bytes of a
  // flushed hex escape followed by the byte that ended it.
  localparam int MAX_BYTES = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [7:0] CTL_BEL = 8'h07;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_HT  = 8'h09;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_VT  = 8'h0B;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_CR  = 8'h0D;

  // One queued command: count bytes from bytes[0] upward; last marks the
  // final byte of the command as the end of the string.
  typedef struct packed {
    logic [2:0]           count;
    logic                 last;
    logic [3:0][7:0]      bytes;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][7:0] bytes;
  } utf8_t;

endpackage
`default_nettype wire

// ===== src/escape_sequence_unescaper_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Beat payload
// s_*     | in  | tdata[7:0] = in_byte (string byte, zero ends the string)
// m_*     | out | tdata[7:0] = out_byte, tlast = is_last (terminator beat)
//
// One input beat is taken per cycle while the command queue has room; the
// decoder keeps the escape state and turns each beat into zero to four
// output bytes in the same cycle.
// The output stage sends one byte per cycle from its current command while
// the output side takes it; the input side keeps running until the queue
// of QUEUE_DEPTH commands fills.
// Reset is synchronous and active high; it returns the decoder to normal
// mode and empties the queue and the output stage.
// Either side may stall at any time; data waiting at the output is held
// steady until it is taken.
module escape_sequence_unescaper_unit
  import esu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast
);

  cmd_t cmd;
  cmd_t head_cmd;
  logic cmd_push;
  logic q_not_full;
  logic q_not_empty;
  logic q_pop;
  logic in_fire;

  // Each accepted beat may need one queue slot, so the input is held off
  // only when the queue is full.
  assign s_tready = q_not_full;
  assign in_fire  = s_tvalid && s_tready;

  // Front end: escape state machine and byte expansion.
  esu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_byte  (s_tdata),
    .cmd      (cmd),
    .cmd_push (cmd_push)
  );

  // Commands that carry at least one byte wait here for the output stage.
  esu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_cmd  (cmd),
    .pop       (q_pop),
    .head_cmd  (head_cmd),
    .not_full  (q_not_full),
    .not_empty (q_not_empty)
  );

  // Back end: sends the bytes of each command, one byte per output beat.
  esu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_cmd   (head_cmd),
    .head_valid (q_not_empty),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule
`default_nettype wire

// ===== src/esu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module esu_front
  import esu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_fire,
  input  wire logic [7:0] in_byte,
  output cmd_t            cmd,
  output logic            cmd_push
);

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_HEX    = 2'd2;

  logic [1:0]  mode, mode_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [2:0]  digits_seen, digits_seen_next;
  logic        is_long_hex, is_long_hex_next;

  logic        dig_ok;
  logic [3:0]  dig_val;
  logic [15:0] acc_shift;
  logic [2:0]  digits_inc;
  logic [2:0]  limit;
  logic        do_flush;
  logic [15:0] flush_val;
  utf8_t       enc;
  logic        esc_prefix;
  logic        plain_on;
  logic        plain_emit;
  logic [7:0]  plain_val;
  logic        plain_last;
  logic [1:0]  head_len;
  logic [2:0][7:0] head;

  function automatic utf8_t utf8_enc(input logic [15:0] v);
    utf8_t r;
    r = '0;
    if (v == 16'h0000) begin
      r.len = 2'd0;
    end else if (v < 16'h0080) begin
      r.len      = 2'd1;
      r.bytes[0] = v[7:0];
    end else if (v < 16'h0800) begin
      r.len      = 2'd2;
      r.bytes[0] = {3'b110, v[10:6]};
      r.bytes[1] = {2'b10, v[5:0]};
    end else begin
      r.len      = 2'd3;
      r.bytes[0] = {4'b1110, v[15:12]};
      r.bytes[1] = {2'b10, v[11:6]};
      r.bytes[2] = {2'b10, v[5:0]};
    end
    return r;
  endfunction

  always_comb begin
    dig_ok  = 1'b1;
    dig_val = in_byte[3:0];
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      dig_val = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      dig_val = in_byte[3:0] + 4'd9;
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign acc_shift  = {hex_accum[11:0], dig_val};
  assign digits_inc = digits_seen + 3'd1;
  assign limit      = is_long_hex ? 3'd4 : 3'd2;
  assign enc        = utf8_enc(flush_val);

  always_comb begin
    mode_next        = mode;
    hex_accum_next   = hex_accum;
    digits_seen_next = digits_seen;
    is_long_hex_next = is_long_hex;
    do_flush         = 1'b0;
    flush_val        = hex_accum;
    esc_prefix       = 1'b0;
    plain_on         = 1'b0;
    plain_emit       = 1'b0;
    plain_val        = in_byte;
    plain_last       = 1'b0;

    case (mode)
      MODE_ESCAPE: begin
        mode_next  = MODE_NORMAL;
        plain_emit = 1'b1;
        case (in_byte)
          CH_A:     plain_val = CTL_BEL;
          CH_B:     plain_val = CTL_BS;
          CH_F:     plain_val = CTL_FF;
          CH_N:     plain_val = CTL_LF;
          CH_R:     plain_val = CTL_CR;
          CH_T:     plain_val = CTL_HT;
          CH_V:     plain_val = CTL_VT;
          CH_ZERO:  plain_val = CH_NUL;
          CH_DQUOT: plain_val = CH_DQUOT;
          CH_SQUOT: plain_val = CH_SQUOT;
          CH_BSL:   plain_val = CH_BSL;
          CH_X, CH_U: begin
            plain_emit       = 1'b0;
            mode_next        = MODE_HEX;
            hex_accum_next   = '0;
            digits_seen_next = '0;
            is_long_hex_next = (in_byte == CH_U);
          end
          default: begin
            plain_emit = 1'b0;
            esc_prefix = 1'b1;
            plain_on   = 1'b1;
          end
        endcase
      end
      MODE_HEX: begin
        if (dig_ok) begin
          hex_accum_next   = acc_shift;
          digits_seen_next = digits_inc;
          if (digits_inc >= limit) begin
            do_flush = 1'b1;
            flush_val = acc_shift;
          end
        end else begin
          do_flush = 1'b1;
          plain_on = 1'b1;
        end
        if (do_flush) begin
          hex_accum_next   = '0;
          digits_seen_next = '0;
          mode_next        = MODE_NORMAL;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
        plain_on  = 1'b1;
      end
    endcase

    // Ordinary byte handling: the terminator ends the string, a backslash
    // opens an escape, anything else passes.
    if (plain_on) begin
      if (in_byte == CH_NUL) begin
        plain_emit = 1'b1;
        plain_last = 1'b1;
      end else if (in_byte == CH_BSL) begin
        mode_next = MODE_ESCAPE;
      end else begin
        plain_emit = 1'b1;
      end
    end
  end

  // The head of a command is either a passed-through backslash or the UTF-8
  // bytes of a flushed hex value; never both.
  always_comb begin
    head     = '0;
    head_len = 2'd0;
    if (esc_prefix) begin
      head[0]  = CH_BSL;
      head_len = 2'd1;
    end else if (do_flush) begin
      head     = enc.bytes;
      head_len = enc.len;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.bytes[0] = head[0];
    cmd.bytes[1] = head[1];
    cmd.bytes[2] = head[2];
    if (plain_emit) begin
      cmd.bytes[head_len] = plain_val;
    end
    cmd.count = {1'b0, head_len} + {2'b00, plain_emit};
    cmd.last  = plain_last;
  end

  assign cmd_push = in_fire && (cmd.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      hex_accum   <= '0;
      digits_seen <= '0;
      is_long_hex <= 1'b0;
    end else if (in_fire) begin
      mode        <= mode_next;
      hex_accum   <= hex_accum_next;
      digits_seen <= digits_seen_next;
      is_long_hex <= is_long_hex_next;
    end
  end

  // A digit count never passes the limit of the escape that is open.
  assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_HEX) |-> (digits_seen < limit))
    else $error("hex digit count reached its limit without a flush");

endmodule
`default_nettype wire

// ===== src/esu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module esu_queue
  import esu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output logic      not_full,
  output logic      not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign not_full  = (fill != CNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign head_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> not_full)
    else $error("command pushed into a full queue");

  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("command popped from an empty queue");

endmodule
`default_nettype wire

// ===== src/esu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module esu_back
  import esu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  cmd_t            head_cmd,
  input  wire logic       head_valid,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       at_end;
  logic       fire;

  assign at_end    = (({1'b0, idx} + 3'd1) == cur.count);
  assign fire      = cur_valid && out_ready;
  assign pop       = head_valid && (!cur_valid || (fire && at_end));
  assign out_valid = cur_valid;
  assign out_byte  = cur.bytes[idx];
  assign out_last  = cur.last && at_end;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (fire) begin
      if (at_end) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.count != 3'd0 && cur.count <= 3'(MAX_BYTES)))
    else $error("empty or oversized command in the output stage");

  assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> ({1'b0, idx} < cur.count))
    else $error("byte index ran past the command");

endmodule
`default_nettype wire
